FILE: rtl/core/fckv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fckv_pkg
// Shared sizes, operation codes and bundle types of the key/value table.
// ----------------------------------------------------------------------------
package fckv_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;

  // Slot address and entry count widths follow from the capacity.
  localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Widths of the request and result fields on the channels.
  localparam int MODE_FIELD_BITS  = 3;
  localparam int KEY_FIELD_BITS   = 32;
  localparam int VALUE_FIELD_BITS = 64;
  localparam int COUNT_FIELD_BITS = 5;

  localparam logic [MODE_FIELD_BITS-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_FIELD_BITS-1:0] MODE_UPDATE = 3'd1;
  localparam logic [MODE_FIELD_BITS-1:0] MODE_UPSERT = 3'd2;
  localparam logic [MODE_FIELD_BITS-1:0] MODE_ERASE  = 3'd3;
  localparam logic [MODE_FIELD_BITS-1:0] MODE_LOOKUP = 3'd4;

  typedef struct packed {
    logic [MODE_FIELD_BITS-1:0]  mode;
    logic [KEY_FIELD_BITS-1:0]   key;
    logic [VALUE_FIELD_BITS-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                        valid;
    logic                        ok;
    logic [VALUE_FIELD_BITS-1:0] value_out;
    logic [COUNT_FIELD_BITS-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    logic [KEY_BITS-1:0]  data;
  } key_wr_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_BITS-1:0]  addr;
    logic [VALUE_BITS-1:0] data;
  } val_wr_t;

endpackage
`default_nettype wire

FILE: rtl/core/fckv_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fckv_req_if
// Request channel of the key/value table: operation, key and value.
// ----------------------------------------------------------------------------
interface fckv_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [fckv_pkg::MODE_FIELD_BITS-1:0]   mode;
  logic [fckv_pkg::KEY_FIELD_BITS-1:0]    key;
  logic [fckv_pkg::VALUE_FIELD_BITS-1:0]  value_in;

  modport source (output valid, output mode, output key, output value_in, input ready);
  modport sink   (input valid, input mode, input key, input value_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fckv_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fckv_rsp_if
// Result channel of the key/value table: status, value and entry count.
// ----------------------------------------------------------------------------
interface fckv_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   ok;
  logic [fckv_pkg::VALUE_FIELD_BITS-1:0]  value_out;
  logic [fckv_pkg::COUNT_FIELD_BITS-1:0]  entry_count;

  modport source (output valid, output ok, output value_out, output entry_count, input ready);
  modport sink   (input valid, input ok, input value_out, input entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fixed_capacity_key_value_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_capacity_key_value_table
// Fixed-capacity key/value table with insert, update, upsert, erase and lookup.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                         handshake
//   req      in         mode, key, value_in             valid / ready
//   rsp      out        ok, value_out, entry_count      valid / ready
//
// A request runs from acceptance to its result in the output register
// through a scan over the key RAM, one slot read per cycle through its
// single read port, then a compare of the last key read, then the
// decision step, the value RAM read for a lookup that hits, and the
// hand-over step. The next request is taken only after the hand-over.
// Reset clears the valid bits and the entry count; the key and
// value RAMs are not cleared, as only valid slots are ever compared or read.
// A result waiting in the output register does not block the next request;
// a second result waits in the engine until the register frees up.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_table (
  input  wire logic  clk,
  input  wire logic  rst,
  fckv_req_if.sink   req,
  fckv_rsp_if.source rsp
);

  fckv_pkg::req_t                        req_data;
  fckv_pkg::res_t                        res;
  logic                                  res_ready;
  fckv_pkg::key_wr_t                     key_wr;
  fckv_pkg::val_wr_t                     val_wr;
  logic [fckv_pkg::SLOT_BITS-1:0]        key_raddr;
  logic [fckv_pkg::SLOT_BITS-1:0]        val_raddr;
  logic [fckv_pkg::KEY_BITS-1:0]         key_rdata;
  logic [fckv_pkg::VALUE_BITS-1:0]       val_rdata;

  // Output register state.
  logic                                  rsp_valid;
  logic                                  rsp_ok;
  logic [fckv_pkg::VALUE_FIELD_BITS-1:0] rsp_value;
  logic [fckv_pkg::COUNT_FIELD_BITS-1:0] rsp_count;

  assign req_data.mode     = req.mode;
  assign req_data.key      = req.key;
  assign req_data.value_in = req.value_in;

  // The engine may hand over a result whenever the register is empty or
  // its current result is being taken in this cycle.
  assign res_ready = !rsp_valid || rsp.ready;

  fckv_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_data  (req_data),
    .req_ready (req.ready),
    .res       (res),
    .res_ready (res_ready),
    .key_wr    (key_wr),
    .val_wr    (val_wr),
    .key_raddr (key_raddr),
    .val_raddr (val_raddr),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata)
  );

  // Keys of all slots; read once per cycle during the scan.
  fckv_ram #(
    .WIDTH     (fckv_pkg::KEY_BITS),
    .DEPTH     (fckv_pkg::CAPACITY),
    .ADDR_BITS (fckv_pkg::SLOT_BITS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_wr.en),
    .waddr (key_wr.addr),
    .wdata (key_wr.data),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Values of all slots; the read data is used only for a lookup that found its key.
  fckv_ram #(
    .WIDTH     (fckv_pkg::VALUE_BITS),
    .DEPTH     (fckv_pkg::CAPACITY),
    .ADDR_BITS (fckv_pkg::SLOT_BITS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_wr.en),
    .waddr (val_wr.addr),
    .wdata (val_wr.data),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      rsp_ok    <= res.ok;
      rsp_value <= res.value_out;
      rsp_count <= res.entry_count;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.value_out   = rsp_value;
  assign rsp.entry_count = rsp_count;

endmodule
`default_nettype wire

FILE: rtl/core/fckv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fckv_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fckv_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/fckv_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fckv_engine
// Sequencer: scans the key RAM for a match and a free slot, then acts.
// ----------------------------------------------------------------------------
module fckv_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  input  wire fckv_pkg::req_t                      req_data,
  output logic                                     req_ready,
  output fckv_pkg::res_t                           res,
  input  wire logic                                res_ready,
  output fckv_pkg::key_wr_t                        key_wr,
  output fckv_pkg::val_wr_t                        val_wr,
  output logic [fckv_pkg::SLOT_BITS-1:0]           key_raddr,
  output logic [fckv_pkg::SLOT_BITS-1:0]           val_raddr,
  input  wire logic [fckv_pkg::KEY_BITS-1:0]       key_rdata,
  input  wire logic [fckv_pkg::VALUE_BITS-1:0]     val_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_VREAD  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam logic [fckv_pkg::COUNT_BITS-1:0] CAP_COUNT =
    fckv_pkg::COUNT_BITS'(fckv_pkg::CAPACITY);

  logic [2:0]                              state;
  logic [fckv_pkg::MODE_FIELD_BITS-1:0]    mode_q;
  logic [fckv_pkg::KEY_BITS-1:0]           key_q;
  logic [fckv_pkg::VALUE_BITS-1:0]         value_q;
  logic [fckv_pkg::COUNT_BITS-1:0]         idx;
  logic                                    pend;
  logic [fckv_pkg::SLOT_BITS-1:0]          pend_idx;
  logic                                    pend_valid;
  logic                                    hit;
  logic [fckv_pkg::SLOT_BITS-1:0]          hit_at;
  logic                                    has_free;
  logic [fckv_pkg::SLOT_BITS-1:0]          free_at;
  logic [fckv_pkg::CAPACITY-1:0]           slot_valid;
  logic [fckv_pkg::COUNT_BITS-1:0]         count;
  logic                                    res_ok;
  logic [fckv_pkg::VALUE_BITS-1:0]         res_value;
  logic [fckv_pkg::COUNT_BITS-1:0]         res_count;

  logic                                    scan_live;
  logic [fckv_pkg::SLOT_BITS-1:0]          scan_addr;
  logic                                    do_ins;
  logic                                    do_upd;
  logic                                    do_ers;
  logic                                    do_look;
  logic [fckv_pkg::COUNT_BITS-1:0]         count_next;

  assign scan_live = (idx < CAP_COUNT);
  assign scan_addr = scan_live ? idx[fckv_pkg::SLOT_BITS-1:0] : '0;
  assign key_raddr = scan_addr;
  assign val_raddr = hit_at;
  assign req_ready = (state == S_IDLE);

  // Action for the request once the scan has settled the match and free slot.
  always_comb begin
    do_ins  = 1'b0;
    do_upd  = 1'b0;
    do_ers  = 1'b0;
    do_look = 1'b0;
    case (mode_q)
      fckv_pkg::MODE_INSERT: begin
        do_ins = !hit && has_free;
      end
      fckv_pkg::MODE_UPDATE: begin
        do_upd = hit;
      end
      fckv_pkg::MODE_UPSERT: begin
        do_upd = hit;
        do_ins = !hit && has_free;
      end
      fckv_pkg::MODE_ERASE: begin
        do_ers = hit;
      end
      fckv_pkg::MODE_LOOKUP: begin
        do_look = hit;
      end
      default: begin
      end
    endcase
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_ers && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    key_wr.en   = (state == S_DECIDE) && do_ins;
    key_wr.addr = free_at;
    key_wr.data = key_q;
    val_wr.en   = (state == S_DECIDE) && (do_ins || do_upd);
    val_wr.addr = do_ins ? free_at : hit_at;
    val_wr.data = value_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
      has_free   <= 1'b0;
      slot_valid <= '0;
      count      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            idx      <= '0;
            pend     <= 1'b0;
            hit      <= 1'b0;
            has_free <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= scan_live;
          if (scan_live) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            if (pend_valid) begin
              if (!hit && (key_rdata == key_q)) begin
                hit <= 1'b1;
              end
            end else if (!has_free) begin
              has_free <= 1'b1;
            end
          end
          if (!scan_live && pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          count <= count_next;
          if (do_ins) begin
            slot_valid[free_at] <= 1'b1;
          end
          if (do_ers) begin
            slot_valid[hit_at] <= 1'b0;
          end
          state <= do_look ? S_VREAD : S_RESP;
        end
        S_VREAD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request copy, compare stage and result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      mode_q  <= req_data.mode;
      key_q   <= req_data.key[fckv_pkg::KEY_BITS-1:0];
      value_q <= req_data.value_in[fckv_pkg::VALUE_BITS-1:0];
    end
    if (state == S_SCAN) begin
      pend_idx   <= scan_addr;
      pend_valid <= slot_valid[scan_addr];
      if (pend) begin
        if (pend_valid) begin
          if (!hit && (key_rdata == key_q)) begin
            hit_at <= pend_idx;
          end
        end else if (!has_free) begin
          free_at <= pend_idx;
        end
      end
    end
    if (state == S_DECIDE) begin
      res_ok    <= do_ins || do_upd || do_ers || do_look;
      res_value <= '0;
      res_count <= count_next;
    end
    if (state == S_VREAD) begin
      res_value <= val_rdata;
    end
  end

  always_comb begin
    res.valid       = (state == S_RESP);
    res.ok          = res_ok;
    res.value_out   = fckv_pkg::VALUE_FIELD_BITS'(res_value);
    res.entry_count = fckv_pkg::COUNT_FIELD_BITS'(res_count);
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(slot_valid))
    else $error("entry count differs from the number of valid slots");

  a_insert_writes_both: assert property (@(posedge clk) disable iff (rst)
    key_wr.en |-> (val_wr.en && (val_wr.addr == key_wr.addr)))
    else $error("key written without its value at the same slot");

  a_scan_ends_in_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_live && pend) |=> (state == S_DECIDE))
    else $error("scan did not hand over to the decision step");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !res_ready) |=> (state == S_RESP && $stable(res_count)
      && $stable(res_ok)))
    else $error("pending result changed before it was taken");
`endif

endmodule
`default_nettype wire
